// ----- rtl/core/ibb_pkg.sv -----
`default_nettype none

package ibb_pkg;

    localparam int HEADER_BYTES        = 54;
    localparam int OFFSET_W            = 22;
    localparam int COLOR_W             = 8;
    localparam int COMP_W              = 6;
    localparam int DATA_W              = 8;
    localparam int CFG_DATA_W          = 11;
    localparam int CFG_IDX_W           = 4;
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_MAX_DIMENSION   = 1024;
    localparam int DEF_IMAGE_WIDTH     = 640;
    localparam int DEF_IMAGE_HEIGHT    = 480;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = t_cfg_idx'(1);

    typedef enum logic {
        PH_PALETTE,
        PH_PIXEL
    } t_phase;

    typedef enum logic [1:0] {
        PC_RED,
        PC_GREEN,
        PC_BLUE
    } t_pal_comp;

    typedef struct packed {
        logic [OFFSET_W-1:0] bmp_offset;
        logic [COLOR_W-1:0]  blue;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  red;
        logic                last_pixel;
    } t_pix_item;

    // A dimension of zero counts as one; anything above the maximum is held at it.
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned max_dim);
        int unsigned r;
        if (v == 0) begin
            r = 1;
        end else if (v > max_dim) begin
            r = max_dim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/indexed_image_to_bgr_bitmap.sv -----
// Converts the body of an indexed image to colors placed in a bottom-up 24-bit BMP.
// Input channel (i_valid / o_stall): one body byte per transfer. The first
// 3*PALETTE_ENTRIES bytes load the palette (red, green, blue, 6 bits each) and
// give no result; every later byte is a pixel index. i_frame_start on a byte
// restarts the palette load with that byte as its first component.
// Output channel (o_valid / i_stall): one transfer per pixel with its color,
// the offset of its blue byte behind the 54-byte header, and a flag on the
// last pixel, after which the next byte starts a new palette.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is the image
// width, index 1 the height. Write only while the block is idle.
// Throughput is one byte per cycle while the input is not stalled. A pixel's
// palette entry is read at its transfer; the result then passes through the
// queue into the output register. The input stalls in the first cycle after
// reset, in the cycle after each configuration write, and while the read
// stage and the four-entry queue together hold four pixels.
// Reset sets width 640 and height 480 and starts a palette load; palette
// contents are undefined until loaded. A stalled output holds its result while
// the queue keeps taking pixels until it fills.
`default_nettype none

module indexed_image_to_bgr_bitmap #(
    parameter int PALETTE_ENTRIES = ibb_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_DIMENSION   = ibb_pkg::DEF_MAX_DIMENSION
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [ibb_pkg::DATA_W-1:0]      i_data_byte,
    input  wire logic                            i_frame_start,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ibb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ibb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ibb_pkg::OFFSET_W-1:0]         o_bmp_offset,
    output logic [ibb_pkg::COLOR_W-1:0]          o_blue,
    output logic [ibb_pkg::COLOR_W-1:0]          o_green,
    output logic [ibb_pkg::COLOR_W-1:0]          o_red,
    output logic                                 o_last_pixel
);

    import ibb_pkg::*;

    logic               push;
    t_pix_item          push_item;
    t_pix_item          out_item;
    logic [Q_CNT_W-1:0] q_count;

    ibb_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_DIMENSION   (MAX_DIMENSION)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_item        (push_item)
    );

    ibb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_count (q_count),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (out_item)
    );

    assign o_bmp_offset = out_item.bmp_offset;
    assign o_blue       = out_item.blue;
    assign o_green      = out_item.green;
    assign o_red        = out_item.red;
    assign o_last_pixel = out_item.last_pixel;

endmodule

`default_nettype wire

// ----- rtl/core/ibb_ram.sv -----
`default_nettype none

module ibb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ibb_front.sv -----
`default_nettype none

module ibb_front #(
    parameter int PALETTE_ENTRIES = ibb_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_DIMENSION   = ibb_pkg::DEF_MAX_DIMENSION
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [ibb_pkg::DATA_W-1:0]      i_data_byte,
    input  wire logic                            i_frame_start,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ibb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ibb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [ibb_pkg::Q_CNT_W-1:0]     i_q_count,
    output logic                                 o_push,
    output ibb_pkg::t_pix_item                   o_item
);

    import ibb_pkg::*;

    localparam int ENTRY_W = $clog2(PALETTE_ENTRIES);
    localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
    localparam int COL3_W  = DIM_W + 2;
    localparam int BASE_W  = $clog2(HEADER_BYTES + 3 * MAX_DIMENSION * MAX_DIMENSION + 1);
    localparam int PROD_W  = DIM_W + COL3_W;
    localparam int RGB_W   = 3 * COLOR_W;

    // Configuration, stored already clamped, and values derived from it.
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    logic [COL3_W-1:0] r_w3;
    logic [BASE_W-1:0] r_w3p54;
    logic [BASE_W-1:0] r_prod;
    logic              r_cfg_hold;

    t_phase            r_phase,    n_phase;
    t_pal_comp         r_pal_comp, n_pal_comp;
    logic [ENTRY_W-1:0] r_entry,   n_entry;
    logic [COMP_W-1:0] r_red,      n_red;
    logic [COMP_W-1:0] r_green,    n_green;
    logic [DIM_W-1:0]  r_col,      n_col;
    logic [COL3_W-1:0] r_col3,     n_col3;
    logic [BASE_W-1:0] r_base,     n_base;

    logic                r_s1_valid,  n_s1_valid;
    logic [OFFSET_W-1:0] r_s1_offset, n_s1_offset;
    logic                r_s1_black,  n_s1_black;
    logic                r_s1_last,   n_s1_last;

    logic               accept;
    logic               ram_we;
    logic               ram_re;
    logic [RGB_W-1:0]   ram_wdata;
    logic [RGB_W-1:0]   ram_rdata;
    logic [ENTRY_W-1:0] entry_eff;
    t_pal_comp          comp_eff;
    logic [COMP_W-1:0]  comp;
    logic               pal_done;
    logic               row_end;
    logic [COL3_W-1:0]  w3_now;
    logic [PROD_W-1:0]  prod_full;

    assign o_cfg_ready = 1'b1;

    // The derived registers are loaded from the stored configuration in the cycle
    // after a write, so input transfers are held off in that cycle.
    assign o_stall = r_cfg_hold
                   || ((Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_s1_valid)
                       >= (Q_CNT_W + 1)'(Q_DEPTH));
    assign accept  = i_valid && !o_stall;

    assign w3_now    = COL3_W'(r_w) + (COL3_W'(r_w) << 1);
    assign prod_full = PROD_W'(r_h - DIM_W'(1)) * PROD_W'(w3_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= DIM_W'(clamp_dim(DEF_IMAGE_WIDTH, MAX_DIMENSION));
            r_h        <= DIM_W'(clamp_dim(DEF_IMAGE_HEIGHT, MAX_DIMENSION));
            r_cfg_hold <= 1'b1;
        end else begin
            r_cfg_hold <= i_cfg_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_w <= DIM_W'(clamp_dim(32'(i_cfg_data), MAX_DIMENSION));
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_h <= DIM_W'(clamp_dim(32'(i_cfg_data), MAX_DIMENSION));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w3    <= w3_now;
        r_w3p54 <= BASE_W'(w3_now) + BASE_W'(HEADER_BYTES);
        r_prod  <= BASE_W'(prod_full);
    end

    assign comp      = i_data_byte[COMP_W-1:0];
    assign comp_eff  = i_frame_start ? PC_RED : r_pal_comp;
    assign entry_eff = i_frame_start ? '0 : r_entry;
    assign pal_done  = (entry_eff == ENTRY_W'(PALETTE_ENTRIES - 1)) && (comp_eff == PC_BLUE);
    assign row_end   = ((DIM_W + 1)'(r_col) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(r_w);
    assign ram_wdata = {comp, 2'b00, r_green, 2'b00, r_red, 2'b00};

    always_comb begin
        n_phase     = r_phase;
        n_pal_comp  = r_pal_comp;
        n_entry     = r_entry;
        n_red       = r_red;
        n_green     = r_green;
        n_col       = r_col;
        n_col3      = r_col3;
        n_base      = r_base;
        n_s1_valid  = 1'b0;
        n_s1_offset = r_s1_offset;
        n_s1_black  = r_s1_black;
        n_s1_last   = r_s1_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        if (accept) begin
            if (i_frame_start || (r_phase == PH_PALETTE)) begin
                n_phase = PH_PALETTE;
                case (comp_eff)
                    PC_RED: begin
                        n_red      = comp;
                        n_pal_comp = PC_GREEN;
                        n_entry    = entry_eff;
                    end
                    PC_GREEN: begin
                        n_green    = comp;
                        n_pal_comp = PC_BLUE;
                        n_entry    = entry_eff;
                    end
                    PC_BLUE: begin
                        ram_we     = 1'b1;
                        n_pal_comp = PC_RED;
                        n_entry    = entry_eff + ENTRY_W'(1);
                    end
                    default: begin
                        n_pal_comp = PC_RED;
                    end
                endcase
                if (pal_done) begin
                    n_entry = '0;
                    n_phase = PH_PIXEL;
                    n_col   = '0;
                    n_col3  = '0;
                    n_base  = BASE_W'(HEADER_BYTES) + r_prod;
                end
            end else begin
                ram_re      = 1'b1;
                n_s1_valid  = 1'b1;
                n_s1_offset = OFFSET_W'(r_base + BASE_W'(r_col3));
                n_s1_black  = 32'(i_data_byte) >= 32'(PALETTE_ENTRIES);
                n_s1_last   = 1'b0;
                if (row_end) begin
                    n_col  = '0;
                    n_col3 = '0;
                    if (r_base <= BASE_W'(HEADER_BYTES)) begin
                        n_s1_last  = 1'b1;
                        n_phase    = PH_PALETTE;
                        n_pal_comp = PC_RED;
                        n_entry    = '0;
                    end else if (r_base < r_w3p54) begin
                        n_base = BASE_W'(HEADER_BYTES);
                    end else begin
                        n_base = r_base - BASE_W'(r_w3);
                    end
                end else begin
                    n_col  = r_col + DIM_W'(1);
                    n_col3 = r_col3 + COL3_W'(3);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PALETTE;
            r_pal_comp <= PC_RED;
            r_entry    <= '0;
            r_red      <= '0;
            r_green    <= '0;
            r_col      <= '0;
            r_col3     <= '0;
            r_base     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pal_comp <= n_pal_comp;
            r_entry    <= n_entry;
            r_red      <= n_red;
            r_green    <= n_green;
            r_col      <= n_col;
            r_col3     <= n_col3;
            r_base     <= n_base;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_offset <= n_s1_offset;
        r_s1_black  <= n_s1_black;
        r_s1_last   <= n_s1_last;
    end

    ibb_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (entry_eff),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (i_data_byte[ENTRY_W-1:0]),
        .o_rd_data (ram_rdata)
    );

    // The palette read lands in the cycle after the transfer; the queue always has
    // room for it because the input stalls early.
    assign o_push            = r_s1_valid;
    assign o_item.bmp_offset = r_s1_offset;
    assign o_item.blue       = r_s1_black ? '0 : ram_rdata[3*COLOR_W-1:2*COLOR_W];
    assign o_item.green      = r_s1_black ? '0 : ram_rdata[2*COLOR_W-1:COLOR_W];
    assign o_item.red        = r_s1_black ? '0 : ram_rdata[COLOR_W-1:0];
    assign o_item.last_pixel = r_s1_last;

endmodule

`default_nettype wire

// ----- rtl/core/ibb_back.sv -----
`default_nettype none

module ibb_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire ibb_pkg::t_pix_item          i_item,
    output logic [ibb_pkg::Q_CNT_W-1:0]      o_count,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output ibb_pkg::t_pix_item               o_item
);

    import ibb_pkg::*;

    t_pix_item            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 r_out_valid;
    t_pix_item            r_out;
    logic                 pop;

    // Move the queue head into the output register whenever that register is
    // free or its contents are being transferred out this cycle.
    assign pop = (r_count != '0) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_item;
        end
        if (pop) begin
            r_out <= r_q[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(pop);
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_count = r_count;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CNT_W'(Q_DEPTH)) |-> !i_push)
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_phantom_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && (r_count == '0)) |=> !r_out_valid)
        else $error("output became valid with nothing queued");

    a_stalled_output_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && (r_count == $past(r_count)
            + Q_CNT_W'($past(i_push)))))
        else $error("stalled output lost or queue drained under stall");

endmodule

`default_nettype wire

// ----- tb/indexed_image_to_bgr_bitmap_tb.sv -----
`default_nettype none

module indexed_image_to_bgr_bitmap_tb;

    import ibb_pkg::*;

    localparam int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES;
    localparam int MAX_DIMENSION   = DEF_MAX_DIMENSION;
    localparam int PALETTE_BYTES   = 3 * PALETTE_ENTRIES;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DEFAULT_PIXELS  = 42;
    localparam int STALL_PIXELS    = 40;
    localparam int PARTIAL_BYTES   = 30;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [DATA_W-1:0]     i_data_byte   = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [OFFSET_W-1:0]   o_bmp_offset;
    logic [COLOR_W-1:0]    o_blue;
    logic [COLOR_W-1:0]    o_green;
    logic [COLOR_W-1:0]    o_red;
    logic                  o_last_pixel;

    // Shadow of the block's registers and conversion state.
    logic [CFG_DATA_W-1:0] reg_width  = CFG_DATA_W'(DEF_IMAGE_WIDTH);
    logic [CFG_DATA_W-1:0] reg_height = CFG_DATA_W'(DEF_IMAGE_HEIGHT);
    logic [23:0]           palette_bgr [PALETTE_ENTRIES];
    int unsigned           pal_count  = 0;
    logic [COMP_W-1:0]     part_red   = '0;
    logic [COMP_W-1:0]     part_green = '0;
    int unsigned           col        = 0;
    int unsigned           row_base   = 0;
    t_phase                load_phase = PH_PALETTE;

    t_pix_item   pending_pixels [$];
    int unsigned error_count  = 0;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned quiet_cycles = 0;

    indexed_image_to_bgr_bitmap #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .MAX_DIMENSION  (MAX_DIMENSION)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_bmp_offset (o_bmp_offset),
        .o_blue       (o_blue),
        .o_green      (o_green),
        .o_red        (o_red),
        .o_last_pixel (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_dim(input logic [CFG_DATA_W-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > MAX_DIMENSION) begin
            return MAX_DIMENSION;
        end
        return 32'(raw);
    endfunction

    function automatic void apply_idling(input t_idle_mode m);
        idle_pct  = (m == IDLE_SENDER)   ? 59 : (m == IDLE_BOTH) ? 19 : 0;
        stall_pct = (m == IDLE_RECEIVER) ? 59 : (m == IDLE_BOTH) ? 19 : 0;
    endfunction

    // Follows one accepted byte: palette bytes update the color table, pixel
    // bytes produce the expected color and its place in the bitmap.
    task automatic place_pixel_byte(input logic [DATA_W-1:0] b, input logic fs);
        int unsigned w;
        int unsigned h;
        logic [23:0] color;
        t_pix_item   px;
        if (fs) begin
            load_phase = PH_PALETTE;
            pal_count  = 0;
        end
        if (load_phase == PH_PALETTE) begin
            case (t_pal_comp'(pal_count % 3))
                PC_RED: begin
                    part_red = b[COMP_W-1:0];
                end
                PC_GREEN: begin
                    part_green = b[COMP_W-1:0];
                end
                default: begin
                    palette_bgr[pal_count / 3] = {b[COMP_W-1:0], 2'b00,
                                                  part_green, 2'b00, part_red, 2'b00};
                end
            endcase
            if (pal_count + 1 >= PALETTE_BYTES) begin
                w          = effective_dim(reg_width);
                h          = effective_dim(reg_height);
                pal_count  = 0;
                load_phase = PH_PIXEL;
                col        = 0;
                row_base   = HEADER_BYTES + (h - 1) * 3 * w;
            end else begin
                pal_count++;
            end
        end else begin
            w             = effective_dim(reg_width);
            color         = (b < PALETTE_ENTRIES) ? palette_bgr[b] : '0;
            px.bmp_offset = OFFSET_W'(row_base + 3 * col);
            px.blue       = color[23:16];
            px.green      = color[15:8];
            px.red        = color[7:0];
            px.last_pixel = 1'b0;
            if (col + 1 >= w) begin
                col = 0;
                if (row_base <= HEADER_BYTES) begin
                    px.last_pixel = 1'b1;
                    load_phase    = PH_PALETTE;
                    pal_count     = 0;
                end else if (row_base - HEADER_BYTES < 3 * w) begin
                    // A row step that would run into the header stops at it.
                    row_base = HEADER_BYTES;
                end else begin
                    row_base -= 3 * w;
                end
            end else begin
                col++;
            end
            pending_pixels.push_back(px);
        end
    endtask

    task automatic push_byte(input logic [DATA_W-1:0] b, input logic fs);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        place_pixel_byte(b, fs);
    endtask

    // Holds the input until every pixel has come out, then lets the pipeline settle.
    task automatic wait_until_idle();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_image_size(input logic [CFG_DATA_W-1:0] w,
                                  input logic [CFG_DATA_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        reg_width   = w;
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        reg_height  = h;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_palette(input logic fs_first);
        for (int k = 0; k < PALETTE_BYTES; k++) begin
            push_byte(DATA_W'($urandom), (k == 0) ? fs_first : 1'b0);
        end
    endtask

    // Reset geometry: the first palette after reset needs no frame start, and
    // the first row starts at the offset of the last bitmap row.
    task automatic test_default_geometry();
        apply_idling(IDLE_NONE);
        load_palette(1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        repeat (DEFAULT_PIXELS) push_byte(DATA_W'($urandom), 1'b0);
    endtask

    // A stalling receiver fills the queue and holds the input off.
    task automatic test_output_stall();
        apply_idling(IDLE_RECEIVER);
        repeat (STALL_PIXELS) push_byte(DATA_W'($urandom), 1'b0);
        apply_idling(IDLE_BOTH);
        repeat (STALL_PIXELS) push_byte(DATA_W'($urandom), 1'b0);
    endtask

    // Width changes mid-image: a cut below the current column ends the row at
    // once, and zero or oversized widths are clamped.
    task automatic test_width_change();
        apply_idling(IDLE_NONE);
        wait_until_idle();
        set_image_size(CFG_DATA_W'(1), CFG_DATA_W'(DEF_IMAGE_HEIGHT));
        repeat (4) push_byte(DATA_W'($urandom), 1'b0);
        wait_until_idle();
        set_image_size('1, '0);
        repeat (3) push_byte(DATA_W'($urandom), 1'b0);
        wait_until_idle();
        set_image_size('0, '1);
        repeat (3) push_byte(DATA_W'($urandom), 1'b0);
    endtask

    // A frame start inside an image and again inside the palette restarts the
    // load. The 2x2 image is then widened, so the row step falls short of the
    // header and the last row starts right behind it. After the last pixel the
    // following bytes begin a new palette without a frame start.
    task automatic test_palette_restart();
        apply_idling(IDLE_SENDER);
        push_byte(DATA_W'($urandom), 1'b1);
        repeat (PARTIAL_BYTES - 1) push_byte(DATA_W'($urandom), 1'b0);
        wait_until_idle();
        set_image_size(CFG_DATA_W'(2), CFG_DATA_W'(2));
        load_palette(1'b1);
        push_byte(DATA_W'($urandom), 1'b0);
        wait_until_idle();
        set_image_size(CFG_DATA_W'(4), CFG_DATA_W'(2));
        apply_idling(IDLE_BOTH);
        repeat (7) push_byte(DATA_W'($urandom), 1'b0);
        repeat (PARTIAL_BYTES) push_byte(DATA_W'($urandom), 1'b0);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_pix_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel transfer, expected none got offset %0d",
                         $time, o_bmp_offset);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("bmp_offset", 32'(want.bmp_offset), 32'(o_bmp_offset));
                compare_field("blue", 32'(want.blue), 32'(o_blue));
                compare_field("green", 32'(want.green), 32'(o_green));
                compare_field("red", 32'(want.red), 32'(o_red));
                compare_field("last_pixel", 32'(want.last_pixel), 32'(o_last_pixel));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_geometry();
        test_output_stall();
        test_width_change();
        test_palette_restart();
        wait_until_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
